@@ rtl/lcdw_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types and constants for the character LCD text writer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdw_pkg;

  localparam int COL_W = 6;
  localparam int LINE_W = 3;

  localparam int COLUMNS_DEFAULT = 16;
  localparam int LINES_DEFAULT = 2;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [7:0] HOME_CMD_RESET = 8'h02;

  // control codes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] LINE_STRIDE = 8'h40;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  // register select codes
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // register indexes
  localparam logic REG_HOME_CMD = 1'b0;

  // one byte transfer on the LCD bus
  typedef struct packed {
    logic       rs;
    logic [7:0] data;
  } xfer_t;

endpackage

`default_nettype wire

@@ rtl/lcdw_stream_if.sv @@
// ----------------------------------------------------------------------------
// lcdw_in_if / lcdw_out_if
// Valid/ready channels for text bytes in and nibble transfers out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface lcdw_out_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic [3:0] bus_nibble;
  logic       last_nibble;

  modport source (output valid, output register_select, output bus_nibble,
                  output last_nibble, input ready);
  modport sink (input valid, input register_select, input bus_nibble,
                input last_nibble, output ready);
endinterface

`default_nettype wire

@@ rtl/char_lcd_text_writer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_text_writer
// Turns text bytes into 4-bit LCD bus transfers and tracks the cursor.
// ----------------------------------------------------------------------------
// The first nibble of a byte is offered once the byte reaches the output register.
// Each byte gives two nibble words on the output bus. A new byte can be taken
//   while the pending buffer is empty; NUL bytes are taken every cycle while it is free.
// A one-entry pending buffer in front of the nibble output register keeps
//   ready independent of the output side.
// Reset (synchronous, rst high): cursor at column 1, line 1, home command 0x02,
//   output and pending buffer empty.
`default_nettype none

module char_lcd_text_writer #(
  parameter int COLUMNS = lcdw_pkg::COLUMNS_DEFAULT,
  parameter int LINES = lcdw_pkg::LINES_DEFAULT
) (
  input  wire                           clk,
  input  wire                           rst,
  lcdw_in_if.sink                       in_ch,
  lcdw_out_if.source                    out_ch,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [lcdw_pkg::ADDR_W-1:0]    paddr,
  input  wire [lcdw_pkg::DATA_W-1:0]    pwdata,
  output logic [lcdw_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lcdw_pkg::*;

  localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS);
  localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(LINES);
  localparam logic [COL_W-1:0] COL_ONE = COL_W'(1);
  localparam logic [LINE_W-1:0] LINE_ONE = LINE_W'(1);

  function automatic logic [COL_W-1:0] col_inc(input logic [COL_W-1:0] c);
    logic [COL_W-1:0] t;
    t = c + COL_ONE;
    if (t > COL_MAX || t == '0) begin
      t = COL_ONE;
    end
    return t;
  endfunction

  function automatic logic [COL_W-1:0] col_dec(input logic [COL_W-1:0] c);
    logic [COL_W-1:0] t;
    if (c <= COL_ONE || c > COL_MAX) begin
      t = COL_MAX;
    end else begin
      t = c - COL_ONE;
    end
    return t;
  endfunction

  function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] l);
    logic [LINE_W-1:0] t;
    t = l + LINE_ONE;
    if (t > LINE_MAX || t == '0) begin
      t = LINE_ONE;
    end
    return t;
  endfunction

  // set-address command with the column at 1
  function automatic logic [7:0] addr_cmd(input logic [LINE_W-1:0] l);
    logic [LINE_W-1:0] lm1;
    lm1 = l - LINE_ONE;
    return CMD_SET_ADDR | {lm1[1:0], 6'd0};
  endfunction

  // ---------------- configuration ----------------
  logic [7:0] home_cmd;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HOME_CMD);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HOME_CMD) begin
      prdata = {{(DATA_W-8){1'b0}}, home_cmd};
    end
  end

  // ---------------- cursor and byte decode ----------------
  logic [COL_W-1:0]  cursor_column, cursor_column_next;
  logic [LINE_W-1:0] cursor_line, cursor_line_next;
  logic              emits;
  xfer_t             new_xfer;
  logic [LINE_W-1:0] lf_line;
  logic              in_acc;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign lf_line = line_inc(cursor_line);

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_line_next = cursor_line;
    emits = 1'b1;
    new_xfer.rs = RS_DATA;
    new_xfer.data = in_ch.text_byte;
    unique case (in_ch.text_byte)
      CH_NUL: begin
        emits = 1'b0;
      end
      CH_CR: begin
        cursor_column_next = COL_ONE;
        new_xfer.rs = RS_CMD;
        new_xfer.data = addr_cmd(cursor_line);
      end
      CH_LF: begin
        cursor_line_next = lf_line;
        cursor_column_next = COL_ONE;
        new_xfer.rs = RS_CMD;
        new_xfer.data = addr_cmd(lf_line);
      end
      CH_VT, CH_FF: begin
        cursor_column_next = COL_ONE;
        cursor_line_next = LINE_ONE;
        new_xfer.rs = RS_CMD;
        new_xfer.data = home_cmd;
      end
      CH_BS: begin
        new_xfer.data = CH_SPACE;
        cursor_column_next = col_dec(col_inc(col_dec(cursor_column)));
      end
      default: begin
        cursor_column_next = col_inc(cursor_column);
      end
    endcase
  end

  // ---------------- pending buffer and nibble output ----------------
  logic  busy, busy_next;
  logic  phase, phase_next;
  logic  pend_v, pend_v_next;
  xfer_t cur, cur_next;
  xfer_t pend, pend_next;
  logic  produce;
  logic  stage_free;

  assign in_ch.ready = !pend_v;
  assign produce = in_acc && emits;
  assign stage_free = !busy || (phase && out_ch.ready);

  assign out_ch.valid = busy;
  assign out_ch.register_select = cur.rs;
  assign out_ch.last_nibble = phase;
  assign out_ch.bus_nibble = phase ? cur.data[3:0] : cur.data[7:4];

  always_comb begin
    busy_next = busy;
    phase_next = phase;
    pend_v_next = pend_v;
    cur_next = cur;
    pend_next = pend;
    if (busy && out_ch.ready) begin
      phase_next = !phase;
    end
    if (stage_free) begin
      if (pend_v) begin
        cur_next = pend;
        busy_next = 1'b1;
        phase_next = 1'b0;
        pend_v_next = 1'b0;
      end else if (produce) begin
        cur_next = new_xfer;
        busy_next = 1'b1;
        phase_next = 1'b0;
      end else begin
        busy_next = 1'b0;
        phase_next = 1'b0;
      end
    end else if (produce) begin
      pend_next = new_xfer;
      pend_v_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= 1'b0;
      pend_v <= 1'b0;
      cursor_column <= COL_ONE;
      cursor_line <= LINE_ONE;
      home_cmd <= HOME_CMD_RESET;
    end else begin
      busy <= busy_next;
      phase <= phase_next;
      pend_v <= pend_v_next;
      if (in_acc) begin
        cursor_column <= cursor_column_next;
        cursor_line <= cursor_line_next;
      end
      if (cfg_wr) begin
        home_cmd <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    pend <= pend_next;
  end

  // ---------------- assertions ----------------
  a_low_follows_high: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && !out_ch.last_nibble
      |=> out_ch.valid && out_ch.last_nibble)
    else $error("low nibble did not follow high nibble");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    cursor_column >= COL_ONE && cursor_column <= COL_MAX)
    else $error("cursor column out of range");

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    cursor_line >= LINE_ONE && cursor_line <= LINE_MAX)
    else $error("cursor line out of range");

  a_pend_implies_busy: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> busy)
    else $error("pending word held while output idle");

endmodule

`default_nettype wire

@@ sim/lcdw_checker.sv @@
// ----------------------------------------------------------------------------
// lcdw_checker
// Watches the text and nibble channels and the register port of the LCD text
// writer. It keeps its own cursor and home command, works out the nibble
// words that each accepted text byte must produce, and compares every
// accepted output word with the oldest outstanding one. It also checks
// register readback.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdw_checker #(
  parameter int COLUMNS = lcdw_pkg::COLUMNS_DEFAULT,
  parameter int LINES = lcdw_pkg::LINES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  lcdw_in_if                          in_ch,
  lcdw_out_if                         out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcdw_pkg::ADDR_W-1:0] paddr,
  input  logic [lcdw_pkg::DATA_W-1:0] pwdata,
  input  logic [lcdw_pkg::DATA_W-1:0] prdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          words_due
);
  import lcdw_pkg::*;

  localparam logic [ADDR_W-1:0] HOME_CMD_ADDR = {REG_HOME_CMD, 2'b00};
  localparam logic [COL_W-1:0] COL_ONE = COL_W'(1);
  localparam logic [LINE_W-1:0] LINE_ONE = LINE_W'(1);

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic       last;
  } nibble_word_t;

  nibble_word_t       due_words[$];
  logic [COL_W-1:0]   cursor_col;
  logic [LINE_W-1:0]  cursor_row;
  logic [7:0]         home_cmd;
  int                 errors = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  task automatic queue_byte_xfer(input logic rs, input logic [7:0] data);
    due_words.push_back('{rs, data[7:4], 1'b0});
    due_words.push_back('{rs, data[3:0], 1'b1});
  endtask

  function automatic logic [7:0] set_addr_cmd();
    logic [7:0] cmd;
    cmd = CMD_SET_ADDR | 8'(cursor_col - 1'b1);
    cmd = cmd | 8'(LINE_STRIDE * 8'(cursor_row - 1'b1));
    return cmd;
  endfunction

  task automatic col_forward();
    cursor_col = cursor_col + 1'b1;
    if (cursor_col > COLUMNS || cursor_col < 1) cursor_col = COL_ONE;
  endtask

  task automatic col_back();
    if (cursor_col <= 1 || cursor_col > COLUMNS) cursor_col = COL_W'(COLUMNS);
    else cursor_col = cursor_col - 1'b1;
  endtask

  task automatic track_text_byte(input logic [7:0] ch);
    case (ch)
      CH_NUL: begin
      end
      CH_CR: begin
        cursor_col = COL_ONE;
        queue_byte_xfer(RS_CMD, set_addr_cmd());
      end
      CH_LF: begin
        cursor_row = cursor_row + 1'b1;
        if (cursor_row > LINES || cursor_row < 1) cursor_row = LINE_ONE;
        cursor_col = COL_ONE;
        queue_byte_xfer(RS_CMD, set_addr_cmd());
      end
      CH_VT, CH_FF: begin
        cursor_col = COL_ONE;
        cursor_row = LINE_ONE;
        queue_byte_xfer(RS_CMD, home_cmd);
      end
      CH_BS: begin
        // erase: step back, overwrite with a space, land back on that cell
        col_back();
        queue_byte_xfer(RS_DATA, CH_SPACE);
        col_forward();
        col_back();
      end
      default: begin
        queue_byte_xfer(RS_DATA, ch);
        col_forward();
      end
    endcase
  endtask

  always @(posedge clk) begin
    nibble_word_t got;
    nibble_word_t want;
    if (rst) begin
      due_words.delete();
      cursor_col = COL_ONE;
      cursor_row = LINE_ONE;
      home_cmd = HOME_CMD_RESET;
    end else begin
      // an output word can never come from a byte taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.register_select, out_ch.bus_nibble, out_ch.last_nibble};
        if (due_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word rs=%b nibble=%h last=%b",
                                    got.rs, got.nibble, got.last));
        end else begin
          want = due_words.pop_front();
          if (got.rs !== want.rs)
            report_mismatch($sformatf("register_select %b, want %b", got.rs, want.rs));
          if (got.nibble !== want.nibble)
            report_mismatch($sformatf("bus_nibble %h, want %h", got.nibble, want.nibble));
          if (got.last !== want.last)
            report_mismatch($sformatf("last_nibble %b, want %b", got.last, want.last));
        end
      end
      if (in_ch.valid && in_ch.ready) track_text_byte(in_ch.text_byte);
      if (psel && penable && pready && paddr == HOME_CMD_ADDR) begin
        if (pwrite) begin
          home_cmd = pwdata[7:0];
        end else if (prdata !== DATA_W'(home_cmd)) begin
          report_mismatch($sformatf("home command reads %h, want %h", prdata, home_cmd));
        end
      end
    end
    fail_count <= errors;
    words_due <= due_words.size();
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the character LCD text writer. Sends a directed
// run of control codes and character extremes, then phases of random text
// under several home command settings, with random gaps on the input and
// random stalls on the nibble output. Checking is done by lcdw_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lcdw_pkg::*;

  localparam int PHASES = 6;
  localparam int PHASE_BYTES = 238;
  localparam logic [ADDR_W-1:0] HOME_CMD_ADDR = {REG_HOME_CMD, 2'b00};
  localparam logic [7:0] CTRL_CODES [6] = '{CH_NUL, CH_BS, CH_LF, CH_VT, CH_FF, CH_CR};

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  int                 fail_count;
  int                 words_due;
  bit                 calm;

  lcdw_in_if  in_bus ();
  lcdw_out_if out_bus ();

  always #5 clk = ~clk;

  char_lcd_text_writer DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lcdw_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  task automatic send_text_byte(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.text_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic apb_access(input logic wr, input logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= HOME_CMD_ADDR;
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain_nibbles();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    // a trailing NUL produces no nibble words and never enters the pending buffer
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] draw_text_byte();
    if ($urandom_range(0, 9) < 4) return CTRL_CODES[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  // output side: random stall before each word, none while calm
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
    end
  end

  initial begin
    logic [7:0] directed [23];
    logic [7:0] home_vals [PHASES];
    logic [7:0] b;
    int sent;
    directed = '{CH_BS, 8'h48, 8'hFF, CH_NUL, 8'h01, CH_CR, CH_LF, 8'h80, CH_LF,
                 CH_VT, 8'h7F, CH_FF, 8'h0E, 8'h09, 8'h0F, 8'h07, CH_BS, CH_BS,
                 8'hAA, 8'h55, CH_LF, CH_CR, CH_NUL};
    home_vals = '{8'h00, 8'hFF, 8'h01, 8'($urandom_range(0, 255)), 8'h80,
                  8'($urandom_range(0, 255))};
    calm = 1'b0;
    rst <= 1'b1;
    in_bus.valid <= 1'b0;
    in_bus.text_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset home command still in force here
    foreach (directed[i]) send_text_byte(directed[i]);
    drain_nibbles();

    for (int p = 0; p < PHASES; p++) begin
      apb_access(1'b1, home_vals[p]);
      apb_access(1'b0, 8'h00);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        if (sent % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        b = draw_text_byte();
        send_text_byte(b);
        if (b != CH_NUL) sent++;
      end
      calm = 1'b0;
      drain_nibbles();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
